>>> sv/mae_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mae_pkg: shared types for the MIPS-I integer ALU execute stage
// Operation codes, the instruction beat and the result beat.
// ----------------------------------------------------------------------------
package mae_pkg;

	localparam int unsigned XLEN      = 32;
	localparam int unsigned SHAMT_W   = 5;
	localparam int unsigned IMM_W     = 16;
	localparam int unsigned REG_IDX_W = 5;
	localparam int unsigned CMD_W     = 5;

	typedef enum logic [CMD_W-1:0] {
		OP_SLL   = 5'd0,
		OP_SRL   = 5'd1,
		OP_SRA   = 5'd2,
		OP_SLLV  = 5'd3,
		OP_SRLV  = 5'd4,
		OP_SRAV  = 5'd5,
		OP_ADD   = 5'd6,
		OP_ADDU  = 5'd7,
		OP_SUB   = 5'd8,
		OP_SUBU  = 5'd9,
		OP_AND   = 5'd10,
		OP_OR    = 5'd11,
		OP_XOR   = 5'd12,
		OP_NOR   = 5'd13,
		OP_SLT   = 5'd14,
		OP_SLTU  = 5'd15,
		OP_ADDI  = 5'd16,
		OP_ADDIU = 5'd17,
		OP_SLTI  = 5'd18,
		OP_SLTIU = 5'd19,
		OP_ANDI  = 5'd20,
		OP_ORI   = 5'd21,
		OP_XORI  = 5'd22,
		OP_LUI   = 5'd23
	} mae_op_t;

	typedef enum logic {
		STATUS_OK       = 1'b0,
		STATUS_OVERFLOW = 1'b1
	} mae_status_t;

	typedef struct packed {
		logic [CMD_W-1:0]     command;
		logic [XLEN-1:0]      operand_a;
		logic [XLEN-1:0]      operand_b;
		logic [SHAMT_W-1:0]   shift_amount;
		logic [IMM_W-1:0]     immediate;
		logic [REG_IDX_W-1:0] dest_index;
	} mae_req_t;

	typedef struct packed {
		logic                 write_enable;
		logic [REG_IDX_W-1:0] write_index;
		logic [XLEN-1:0]      write_value;
		logic                 status;
	} mae_rsp_t;

endpackage
`default_nettype wire

>>> sv/mae_stream_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mae_stream_if: valid/ready channel
// Carries one payload beat per cycle in which valid and ready are both high.
// ----------------------------------------------------------------------------
interface mae_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> sv/mips_alu_execute.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mips_alu_execute: MIPS-I integer ALU execute stage
// Two-register pipeline around a combinational ALU, one instruction per clock while the result side is ready.
// ----------------------------------------------------------------------------
//
//   Channel   Dir   Payload     Beat
//   instr     in    mae_req_t   one ALU instruction (command, operands, dest)
//   result    out   mae_rsp_t   write enable, write index, value, status
//
// Every instruction yields exactly one result beat. An accepted instruction is
// held in the instruction register, passes through the ALU and is then held in
// the result register. With the result side always ready the block takes one
// beat per clock.
// Reset clears only the two stage valid flags; payload registers are not reset.
// A stalled result holds in the result register while the instruction register
// still takes one more beat, so throughput stays at one beat per clock as long
// as the consumer keeps up; the ready path runs back through both stages.
// ----------------------------------------------------------------------------
module mips_alu_execute
	import mae_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	mae_stream_if.sink   instr,
	mae_stream_if.source result
);

	// Instruction stage.
	mae_req_t req_s1;
	logic     valid_s1;

	// Result stage.
	mae_rsp_t rsp_s2;
	logic     valid_s2;

	mae_rsp_t alu_rsp;
	logic     load_s2;
	logic     load_s1;

	// The result register may load when it is empty or its beat leaves now.
	assign load_s2 = valid_s1 && (!valid_s2 || result.ready);
	// The instruction register takes a new beat when empty or when it drains.
	assign instr.ready = !valid_s1 || load_s2;
	assign load_s1     = instr.valid && instr.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (instr.ready) begin
				valid_s1 <= instr.valid;
			end
			if (!valid_s2 || result.ready) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			req_s1 <= instr.data;
		end
		if (load_s2) begin
			rsp_s2 <= alu_rsp;
		end
	end

	mae_alu_core u_alu (
		.req (req_s1),
		.rsp (alu_rsp)
	);

	assign result.valid = valid_s2;
	assign result.data  = rsp_s2;

`ifndef ASSERT_OFF
	// An accepted instruction is always present in the instruction stage next.
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		load_s1 |=> valid_s1)
		else $error("accepted instruction did not reach stage 1");

	// A blocked instruction stays put until the result stage can take it.
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !load_s2) |=> (valid_s1 && $stable(req_s1)))
		else $error("stage 1 instruction lost while stalled");

	// The result carries the destination of the instruction it came from.
	a_index_follows: assert property (@(posedge clk) disable iff (!arst_n)
		load_s2 |=> (rsp_s2.write_index == $past(req_s1.dest_index)))
		else $error("result write index does not match its instruction");

	// An overflow result never writes and carries a zero value.
	a_ovf_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && rsp_s2.status == STATUS_OVERFLOW)
			|-> (!rsp_s2.write_enable && rsp_s2.write_value == '0))
		else $error("overflow result would write the register file");
`endif

endmodule
`default_nettype wire

>>> sv/mae_alu_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mae_alu_core: combinational ALU datapath
// Decodes one instruction and forms value, write enable and overflow status.
// ----------------------------------------------------------------------------
module mae_alu_core
	import mae_pkg::*;
(
	input  mae_req_t req,
	output mae_rsp_t rsp
);

	logic [XLEN-1:0]    a, b, se_imm, ze_imm;
	logic [SHAMT_W-1:0] var_sh;
	logic [XLEN-1:0]    sum_ab, diff_ab, sum_ai;
	logic               ovf_add, ovf_sub, ovf_addi;
	logic [XLEN-1:0]    val;
	logic               we, ovf;

	assign a      = req.operand_a;
	assign b      = req.operand_b;
	assign var_sh = a[SHAMT_W-1:0];
	assign se_imm = {{(XLEN-IMM_W){req.immediate[IMM_W-1]}}, req.immediate};
	assign ze_imm = {{(XLEN-IMM_W){1'b0}}, req.immediate};

	assign sum_ab  = a + b;
	assign diff_ab = a - b;
	assign sum_ai  = a + se_imm;

	// Signed overflow: result sign differs from both addends (or, for subtract,
	// operands differ in sign and the result took the sign of the subtrahend).
	assign ovf_add  = (a[XLEN-1] ^ sum_ab[XLEN-1]) & (b[XLEN-1] ^ sum_ab[XLEN-1]);
	assign ovf_sub  = (a[XLEN-1] ^ b[XLEN-1]) & (a[XLEN-1] ^ diff_ab[XLEN-1]);
	assign ovf_addi = (a[XLEN-1] ^ sum_ai[XLEN-1]) & (se_imm[XLEN-1] ^ sum_ai[XLEN-1]);

	always_comb begin
		val = '0;
		we  = 1'b1;
		ovf = 1'b0;
		unique case (req.command)
			OP_SLL:   val = b << req.shift_amount;
			OP_SRL:   val = b >> req.shift_amount;
			OP_SRA:   val = $unsigned($signed(b) >>> req.shift_amount);
			OP_SLLV:  val = b << var_sh;
			OP_SRLV:  val = b >> var_sh;
			OP_SRAV:  val = $unsigned($signed(b) >>> var_sh);
			OP_ADD: begin
				val = sum_ab;
				ovf = ovf_add;
			end
			OP_ADDU:  val = sum_ab;
			OP_SUB: begin
				val = diff_ab;
				ovf = ovf_sub;
			end
			OP_SUBU:  val = diff_ab;
			OP_AND:   val = a & b;
			OP_OR:    val = a | b;
			OP_XOR:   val = a ^ b;
			OP_NOR:   val = ~(a | b);
			OP_SLT:   val = {{(XLEN-1){1'b0}}, ($signed(a) < $signed(b))};
			OP_SLTU:  val = {{(XLEN-1){1'b0}}, (a < b)};
			OP_ADDI: begin
				val = sum_ai;
				ovf = ovf_addi;
			end
			OP_ADDIU: val = sum_ai;
			OP_SLTI:  val = {{(XLEN-1){1'b0}}, ($signed(a) < $signed(se_imm))};
			OP_SLTIU: val = {{(XLEN-1){1'b0}}, (a < se_imm)};
			OP_ANDI:  val = a & ze_imm;
			OP_ORI:   val = a | ze_imm;
			OP_XORI:  val = a ^ ze_imm;
			OP_LUI:   val = {req.immediate, {(XLEN-IMM_W){1'b0}}};
			default: begin
				val = '0;
				we  = 1'b0;
			end
		endcase
		// An overflowing instruction must not update the register file.
		if (ovf) begin
			val = '0;
			we  = 1'b0;
		end
	end

	assign rsp.write_enable = we;
	assign rsp.write_index  = req.dest_index;
	assign rsp.write_value  = val;
	assign rsp.status       = ovf ? STATUS_OVERFLOW : STATUS_OK;

endmodule
`default_nettype wire

>>> sim/mips_alu_execute_tb.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mips_alu_execute_tb: self-checking bench for the MIPS-I ALU execute stage
// Sends directed corner instructions and then random ones through the instr
// channel, predicts every write-back beat in the bench and compares each beat
// on the result channel in order, with random idling on both channels.
// ----------------------------------------------------------------------------
module mips_alu_execute_tb
	import mae_pkg::*;
();

	localparam int unsigned RANDOM_INSTRS = 1150;
	localparam int unsigned CYCLE_LIMIT   = 200000;
	localparam int unsigned DRAIN_CYCLES  = 12;
	// Beat numbers between which neither side idles, so the back-to-back path is hit.
	localparam int unsigned BURST_FIRST   = 400;
	localparam int unsigned BURST_LAST    = 650;
	// Command codes past the last operation.
	localparam logic [CMD_W-1:0] CMD_UNUSED_FIRST = 5'd24;
	localparam logic [CMD_W-1:0] CMD_UNUSED_LAST  = 5'd31;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	always #4 clk = ~clk;

	mae_stream_if #(.payload_t(mae_req_t)) instr_if ();
	mae_stream_if #(.payload_t(mae_rsp_t)) result_if ();

	// Bench-side registers behind the channel inputs, known from time zero.
	logic     drv_valid = 1'b0;
	mae_req_t drv_data = '0;
	logic     sink_ready = 1'b0;

	assign instr_if.valid  = drv_valid;
	assign instr_if.data   = drv_data;
	assign result_if.ready = sink_ready;

	mips_alu_execute dut (
		.clk(clk),
		.arst_n(arst_n),
		.instr(instr_if),
		.result(result_if)
	);

	mae_req_t instr_backlog[$];
	mae_rsp_t pending_writebacks[$];

	logic        instr_taken = 1'b0;
	int unsigned beats_sent = 0;
	int unsigned beats_checked = 0;
	int unsigned overflow_beats = 0;
	int unsigned silent_beats = 0;
	int unsigned directed_count = 0;
	int unsigned mismatches = 0;
	int unsigned cycle_count = 0;

	// Both channels run without gaps while the beat count is inside the burst window.
	wire burst_phase = (beats_sent >= BURST_FIRST) && (beats_sent < BURST_LAST);

	// Predicts the write-back of one instruction. The stage holds no state, so
	// the beat depends on the instruction alone.
	function automatic mae_rsp_t alu_outcome(input mae_req_t req);
		mae_rsp_t        wb;
		logic [XLEN-1:0] a;
		logic [XLEN-1:0] b;
		logic [XLEN-1:0] sext_imm;
		logic [XLEN-1:0] zext_imm;
		logic [4:0]      reg_shift;
		logic            ovf;
		a         = req.operand_a;
		b         = req.operand_b;
		sext_imm  = {{(XLEN-IMM_W){req.immediate[IMM_W-1]}}, req.immediate};
		zext_imm  = {{(XLEN-IMM_W){1'b0}}, req.immediate};
		// Variable shifts look only at the low five bits of rs.
		reg_shift = a[4:0];
		ovf       = 1'b0;
		wb.write_enable = 1'b1;
		wb.write_index  = req.dest_index;
		wb.write_value  = '0;
		case (req.command)
			OP_SLL:   wb.write_value = b << req.shift_amount;
			OP_SRL:   wb.write_value = b >> req.shift_amount;
			OP_SRA:   wb.write_value = $signed(b) >>> req.shift_amount;
			OP_SLLV:  wb.write_value = b << reg_shift;
			OP_SRLV:  wb.write_value = b >> reg_shift;
			OP_SRAV:  wb.write_value = $signed(b) >>> reg_shift;
			OP_ADD: begin
				wb.write_value = a + b;
				ovf = (a[XLEN-1] == b[XLEN-1]) && (wb.write_value[XLEN-1] != a[XLEN-1]);
			end
			OP_ADDU:  wb.write_value = a + b;
			OP_SUB: begin
				wb.write_value = a - b;
				ovf = (a[XLEN-1] != b[XLEN-1]) && (wb.write_value[XLEN-1] != a[XLEN-1]);
			end
			OP_SUBU:  wb.write_value = a - b;
			OP_AND:   wb.write_value = a & b;
			OP_OR:    wb.write_value = a | b;
			OP_XOR:   wb.write_value = a ^ b;
			OP_NOR:   wb.write_value = ~(a | b);
			OP_SLT:   wb.write_value = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
			OP_SLTU:  wb.write_value = (a < b) ? 32'd1 : 32'd0;
			OP_ADDI: begin
				wb.write_value = a + sext_imm;
				ovf = (a[XLEN-1] == sext_imm[XLEN-1]) &&
					(wb.write_value[XLEN-1] != a[XLEN-1]);
			end
			// The immediate of addiu is sign-extended too, without any overflow check.
			OP_ADDIU: wb.write_value = a + sext_imm;
			OP_SLTI:  wb.write_value = ($signed(a) < $signed(sext_imm)) ? 32'd1 : 32'd0;
			OP_SLTIU: wb.write_value = (a < sext_imm) ? 32'd1 : 32'd0;
			OP_ANDI:  wb.write_value = a & zext_imm;
			OP_ORI:   wb.write_value = a | zext_imm;
			OP_XORI:  wb.write_value = a ^ zext_imm;
			OP_LUI:   wb.write_value = {req.immediate, {(XLEN-IMM_W){1'b0}}};
			// Codes past the last operation write nothing and raise no status.
			default:  wb.write_enable = 1'b0;
		endcase
		// A signed overflow zeroes the value and blocks the register write.
		if (ovf) begin
			wb.write_enable = 1'b0;
			wb.write_value  = '0;
		end
		wb.status = ovf ? STATUS_OVERFLOW : STATUS_OK;
		return wb;
	endfunction

	task automatic queue_instr(input logic [CMD_W-1:0] cmd, input logic [XLEN-1:0] a,
			input logic [XLEN-1:0] b, input logic [SHAMT_W-1:0] sa,
			input logic [IMM_W-1:0] imm, input logic [REG_IDX_W-1:0] dst);
		mae_req_t req;
		req.command      = cmd;
		req.operand_a    = a;
		req.operand_b    = b;
		req.shift_amount = sa;
		req.immediate    = imm;
		req.dest_index   = dst;
		instr_backlog.push_back(req);
	endtask

	// Operands lean on the sign boundaries so that overflow and the signed
	// compares flip often, with plain random words and small values mixed in.
	function automatic logic [XLEN-1:0] pick_word();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 8)
			return 32'h7FFF_FFFF - $urandom_range(3);
		else if (roll < 16)
			return 32'h8000_0000 + $urandom_range(3);
		else if (roll < 22)
			return 32'hFFFF_FFFF - $urandom_range(3);
		else if (roll < 28)
			return $urandom_range(3);
		else if (roll < 40)
			return $urandom_range(65535);
		return $urandom;
	endfunction

	function automatic logic [IMM_W-1:0] pick_imm();
		case ($urandom_range(9))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'h7FFF;
			3: return 16'h8000;
			default: return IMM_W'($urandom_range(65535));
		endcase
	endfunction

	// Instruction driver: a new beat is presented at the falling edge once the
	// previous one was taken at the rising edge, or an idle cycle is inserted.
	always @(posedge clk) begin
		instr_taken <= instr_if.valid && instr_if.ready;
	end

	always @(negedge clk) begin
		if (arst_n && (!drv_valid || instr_taken)) begin
			if (instr_backlog.size() != 0 && (burst_phase || $urandom_range(99) >= 36)) begin
				drv_data  <= instr_backlog.pop_front();
				drv_valid <= 1'b1;
			end else begin
				drv_valid <= 1'b0;
			end
		end
	end

	// Result side back-pressure, changed only at the falling edge.
	always @(negedge clk) begin
		if (arst_n)
			sink_ready <= burst_phase || ($urandom_range(99) >= 36);
	end

	// Monitor: an accepted instruction adds its predicted write-back to the
	// queue, and an accepted result beat is compared with the oldest entry.
	always @(posedge clk) begin
		mae_rsp_t want;
		mae_rsp_t got;
		if (arst_n) begin
			if (instr_if.valid && instr_if.ready) begin
				pending_writebacks.push_back(alu_outcome(instr_if.data));
				beats_sent <= beats_sent + 1;
			end
			if (result_if.valid && result_if.ready) begin
				got = result_if.data;
				if (pending_writebacks.size() == 0) begin
					$display("%0t: result beat with none expected: we=%0b idx=%0d val=%h st=%0b",
						$time, got.write_enable, got.write_index, got.write_value, got.status);
					mismatches <= mismatches + 1;
				end else begin
					want = pending_writebacks.pop_front();
					beats_checked <= beats_checked + 1;
					if (want.status == STATUS_OVERFLOW)
						overflow_beats <= overflow_beats + 1;
					if (!want.write_enable)
						silent_beats <= silent_beats + 1;
					if (got !== want) begin
						$display("%0t: write_back mismatch expected we=%0b idx=%0d val=%h st=%0b",
							$time, want.write_enable, want.write_index, want.write_value,
							want.status);
						$display("%0t:                      actual   we=%0b idx=%0d val=%h st=%0b",
							$time, got.write_enable, got.write_index, got.write_value,
							got.status);
						mismatches <= mismatches + 1;
					end
				end
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d beats outstanding", $time,
				pending_writebacks.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		logic [CMD_W-1:0] cmd;
		// Directed corners: every operation at least once, shift and immediate extremes,
		// the three overflow paths, masked register shift counts, sign-extended
		// addiu, unused codes and a write to register zero.
		queue_instr(OP_SLL,   32'h0,         32'hFFFF_FFFF, 5'd31, 16'h0,    5'd31);
		queue_instr(OP_SRL,   32'h0,         32'h8000_0000, 5'd31, 16'hFFFF, 5'd1);
		queue_instr(OP_SRA,   32'h0,         32'h8000_0000, 5'd31, 16'h0,    5'd2);
		queue_instr(OP_SRA,   32'h0,         32'h7FFF_FFFF, 5'd0,  16'h0,    5'd3);
		queue_instr(OP_SLLV,  32'hFFFF_FFE3, 32'h0000_0001, 5'd0,  16'h0,    5'd4);
		queue_instr(OP_SRLV,  32'h0000_003F, 32'hFFFF_FFFF, 5'd0,  16'h0,    5'd5);
		queue_instr(OP_SRAV,  32'hFFFF_FFFF, 32'h8000_0001, 5'd0,  16'h0,    5'd6);
		queue_instr(OP_ADD,   32'h7FFF_FFFF, 32'h0000_0001, 5'd0,  16'h0,    5'd7);
		queue_instr(OP_ADD,   32'h8000_0000, 32'h8000_0000, 5'd0,  16'h0,    5'd8);
		queue_instr(OP_ADD,   32'hFFFF_FFFF, 32'h0000_0001, 5'd0,  16'h0,    5'd9);
		queue_instr(OP_ADDU,  32'hFFFF_FFFF, 32'h0000_0001, 5'd0,  16'h0,    5'd10);
		queue_instr(OP_SUB,   32'h8000_0000, 32'h0000_0001, 5'd0,  16'h0,    5'd11);
		queue_instr(OP_SUB,   32'h7FFF_FFFF, 32'hFFFF_FFFF, 5'd0,  16'h0,    5'd12);
		queue_instr(OP_SUBU,  32'h0,         32'h0000_0001, 5'd0,  16'h0,    5'd13);
		queue_instr(OP_AND,   32'hAAAA_AAAA, 32'hFFFF_0000, 5'd0,  16'h0,    5'd14);
		queue_instr(OP_OR,    32'hAAAA_AAAA, 32'h5555_5555, 5'd0,  16'h0,    5'd15);
		queue_instr(OP_XOR,   32'hAAAA_AAAA, 32'hFFFF_FFFF, 5'd0,  16'h0,    5'd16);
		queue_instr(OP_NOR,   32'h0,         32'h0,         5'd0,  16'h0,    5'd17);
		queue_instr(OP_SLT,   32'h8000_0000, 32'h7FFF_FFFF, 5'd0,  16'h0,    5'd18);
		queue_instr(OP_SLTU,  32'h8000_0000, 32'h7FFF_FFFF, 5'd0,  16'h0,    5'd19);
		queue_instr(OP_ADDI,  32'h7FFF_FFFF, 32'h0,         5'd0,  16'h0001, 5'd20);
		queue_instr(OP_ADDI,  32'h8000_0000, 32'h0,         5'd0,  16'h8000, 5'd21);
		queue_instr(OP_ADDIU, 32'h0,         32'h0,         5'd0,  16'hFFFF, 5'd22);
		queue_instr(OP_SLTI,  32'hFFFF_FFFE, 32'h0,         5'd0,  16'hFFFF, 5'd23);
		queue_instr(OP_SLTIU, 32'h7FFF_FFFF, 32'h0,         5'd0,  16'h8000, 5'd24);
		queue_instr(OP_ANDI,  32'hFFFF_FFFF, 32'h0,         5'd0,  16'hFFFF, 5'd25);
		queue_instr(OP_ORI,   32'h0,         32'h0,         5'd0,  16'hFFFF, 5'd26);
		queue_instr(OP_XORI,  32'hFFFF_FFFF, 32'h0,         5'd0,  16'hFFFF, 5'd27);
		queue_instr(OP_LUI,   32'h0,         32'h0,         5'd0,  16'hFFFF, 5'd0);
		queue_instr(CMD_UNUSED_FIRST, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd31, 16'hFFFF, 5'd28);
		queue_instr(CMD_UNUSED_LAST,  32'h1234_5678, 32'h9ABC_DEF0, 5'd7,  16'h1234, 5'd29);
		directed_count = instr_backlog.size();

		// Random instructions: mostly real operations, a few unused codes.
		repeat (RANDOM_INSTRS) begin
			if ($urandom_range(99) < 5)
				cmd = CMD_W'($urandom_range(CMD_UNUSED_LAST, CMD_UNUSED_FIRST));
			else
				cmd = CMD_W'($urandom_range(OP_LUI, OP_SLL));
			queue_instr(cmd, pick_word(), pick_word(), SHAMT_W'($urandom_range(31)),
				pick_imm(), REG_IDX_W'($urandom_range(31)));
		end

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Wait until every instruction has gone in and every write-back came out.
		while (instr_backlog.size() != 0 || drv_valid || pending_writebacks.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Ran %0d instructions (%0d directed corners) over all 24 operations and",
			beats_checked, directed_count);
		$display("unused codes; %0d raised overflow, %0d produced no register write.",
			overflow_beats, silent_beats);
		if (mismatches == 0 && pending_writebacks.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
`default_nettype wire

>>> files.f
sv/mae_pkg.sv
sv/mae_stream_if.sv
sv/mae_alu_core.sv
sv/mips_alu_execute.sv
sim/mips_alu_execute_tb.sv
